/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, checked only while out of reset.
`define FRG_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property, checked during reset as well.
`define FRG_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FRG_ASSERT(label, clk, rst_n, prop, msg)
`define FRG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* rtl/core/frg_pkg.sv */
// ---------------------------------------------------------------------------
// frg_pkg
// Controller states and the command/status groups between controller and
// datapath of the fraction reducer.
// ---------------------------------------------------------------------------
package frg_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_OUT
  } frg_state_t;

  typedef struct packed {
    logic load;      // capture a new operand pair
    logic gcd_step;  // one binary GCD step
    logic div_init;  // form the divisor and start the dividers
    logic div_step;  // one quotient bit for both dividers
    logic out_load;  // move the result into the output register
  } frg_cmd_t;

  typedef struct packed {
    logic gcd_done;  // one GCD operand has reached zero
    logic div_last;  // last quotient bit is being produced
  } frg_sts_t;

endpackage

/* rtl/core/frg_if.sv */
// ---------------------------------------------------------------------------
// frg_if
// Valid/ready channels for operand pairs and reduced fractions.
// ---------------------------------------------------------------------------
interface frg_in_if #(
  parameter int VALUE_WIDTH = 31
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] numerator;
  logic [VALUE_WIDTH-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frg_out_if #(
  parameter int VALUE_WIDTH = 31
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] reduced_numerator;
  logic [VALUE_WIDTH-1:0] reduced_denominator;
  logic [VALUE_WIDTH-1:0] common_divisor;

  modport source (output valid, output reduced_numerator, output reduced_denominator,
                  output common_divisor, input ready);
  modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                  input common_divisor, output ready);
endinterface

/* rtl/core/frg_datapath.sv */
// ---------------------------------------------------------------------------
// frg_datapath
// Binary GCD engine, two restoring dividers sharing one divisor, and the
// output register.
// ---------------------------------------------------------------------------
module frg_datapath #(
  parameter int VALUE_WIDTH = 31
) (
  input  logic                   clk,
  input  frg_pkg::frg_cmd_t      cmd,
  output frg_pkg::frg_sts_t      sts,
  input  logic [VALUE_WIDTH-1:0] in_numerator,
  input  logic [VALUE_WIDTH-1:0] in_denominator,
  output logic [VALUE_WIDTH-1:0] out_reduced_numerator,
  output logic [VALUE_WIDTH-1:0] out_reduced_denominator,
  output logic [VALUE_WIDTH-1:0] out_common_divisor
);

  localparam int W  = VALUE_WIDTH;
  localparam int KW = $clog2(W);
  localparam int CW = $clog2(W);

  // operands kept for the division phase
  logic [W-1:0]  num_r, den_r;
  // GCD working values and common power of two
  logic [W-1:0]  a_r, a_nxt, b_r, b_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [W-1:0]  g_r;
  logic [W-1:0]  g_full;
  logic [W:0]    diff_ab, diff_ba;
  // divider lanes: 0 = numerator, 1 = denominator
  logic [W-1:0]  q_r   [2];
  logic [W-1:0]  q_nxt [2];
  logic [W-1:0]  rem_r [2];
  logic [W-1:0]  rem_nxt [2];
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  out_num_r, out_den_r, out_gcd_r;

  assign diff_ab = {1'b0, a_r} - {1'b0, b_r};
  assign diff_ba = {1'b0, b_r} - {1'b0, a_r};

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    k_nxt = k_r;
    priority if (!a_r[0] && !b_r[0]) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + 1'b1;
    end else if (!a_r[0]) begin
      a_nxt = a_r >> 1;
    end else if (!b_r[0]) begin
      b_nxt = b_r >> 1;
    end else if (!diff_ab[W]) begin
      a_nxt = diff_ab[W:1];
    end else begin
      b_nxt = diff_ba[W:1];
    end
  end

  assign g_full = (a_r | b_r) << k_r;

  assign sts.gcd_done = (a_r == '0) || (b_r == '0);
  assign sts.div_last = (cnt_r == '0);

  for (genvar i = 0; i < 2; i++) begin : g_lane
    logic [W:0] rem_sh;
    logic [W:0] trial;
    assign rem_sh = {rem_r[i], q_r[i][W-1]};
    assign trial  = rem_sh - {1'b0, g_r};
    always_comb begin
      q_nxt[i]   = {q_r[i][W-2:0], !trial[W]};
      rem_nxt[i] = trial[W] ? rem_sh[W-1:0] : trial[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= in_numerator;
      den_r <= in_denominator;
      a_r   <= in_numerator;
      b_r   <= in_denominator;
      k_r   <= '0;
    end else if (cmd.gcd_step) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      k_r <= k_nxt;
    end
    if (cmd.div_init) begin
      g_r      <= g_full;
      q_r[0]   <= num_r;
      q_r[1]   <= den_r;
      rem_r[0] <= '0;
      rem_r[1] <= '0;
      cnt_r    <= CW'(W - 1);
    end else if (cmd.div_step) begin
      q_r[0]   <= q_nxt[0];
      q_r[1]   <= q_nxt[1];
      rem_r[0] <= rem_nxt[0];
      rem_r[1] <= rem_nxt[1];
      cnt_r    <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      // zero divisor marks a zero/zero input: report 0/1
      if (g_r == '0) begin
        out_num_r <= '0;
        out_den_r <= W'(1);
        out_gcd_r <= '0;
      end else begin
        out_num_r <= q_r[0];
        out_den_r <= q_r[1];
        out_gcd_r <= g_r;
      end
    end
  end

  assign out_reduced_numerator   = out_num_r;
  assign out_reduced_denominator = out_den_r;
  assign out_common_divisor      = out_gcd_r;

endmodule

/* rtl/core/frg_ctrl.sv */
// ---------------------------------------------------------------------------
// frg_ctrl
// Sequencer for the fraction reducer: GCD phase, division phase, handoff to
// the output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module frg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output frg_pkg::frg_cmd_t cmd,
  input  frg_pkg::frg_sts_t sts
);

  frg_pkg::frg_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      frg_pkg::ST_IDLE: if (in_valid) state_nxt = frg_pkg::ST_GCD;
      frg_pkg::ST_GCD:  if (sts.gcd_done) state_nxt = frg_pkg::ST_DIV;
      frg_pkg::ST_DIV:  if (sts.div_last) state_nxt = frg_pkg::ST_OUT;
      frg_pkg::ST_OUT:  if (out_free) state_nxt = frg_pkg::ST_IDLE;
      default:          state_nxt = frg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      frg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      frg_pkg::ST_GCD: begin
        cmd.gcd_step = !sts.gcd_done;
        cmd.div_init = sts.gcd_done;
      end
      frg_pkg::ST_DIV: cmd.div_step = 1'b1;
      frg_pkg::ST_OUT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      // drop the result once its transfer completes
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= frg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `FRG_ASSERT(a_no_overwrite, clk, rst_n, cmd.out_load |-> (!out_valid_r || out_ready), "result overwritten before transfer")
  `FRG_ASSERT(a_single_item, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "second item taken while one is in flight")
  `FRG_ASSERT(a_gcd_stops, clk, rst_n, cmd.gcd_step |-> !sts.gcd_done, "GCD stepped past termination")
  `FRG_ASSERT(a_out_follows_div, clk, rst_n, cmd.out_load |-> $past(sts.div_last) || $past(cmd.out_load == 1'b0 && state_r == frg_pkg::ST_OUT), "result loaded without finished division")
  `FRG_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == frg_pkg::ST_IDLE && !out_valid_r), "reset did not clear controller")

endmodule

/* rtl/core/fraction_reduce_gcd.sv */
// ---------------------------------------------------------------------------
// fraction_reduce_gcd
// Reduces a fraction to lowest terms and returns the common divisor.
// ---------------------------------------------------------------------------
// One operand pair is in work at a time. After a pair is taken, the binary GCD
// engine runs one shift or subtract-and-shift step per cycle, at most
// 2*VALUE_WIDTH steps, then two restoring dividers produce both reduced parts
// in parallel at one quotient bit per cycle. The number of GCD steps depends on
// the operands. The result waits in an output register, so the next pair is
// taken as soon as the previous result has moved there. A zero numerator gives
// 0/1 with the denominator as divisor; zero over zero gives 0/1 with divisor 0.
module fraction_reduce_gcd #(
  parameter int VALUE_WIDTH = 31
) (
  input logic clk,
  input logic rst_n,
  frg_in_if.sink    in_ch,
  frg_out_if.source out_ch
);

  frg_pkg::frg_cmd_t cmd;
  frg_pkg::frg_sts_t sts;

  frg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  frg_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk                     (clk),
    .cmd                     (cmd),
    .sts                     (sts),
    .in_numerator            (in_ch.numerator),
    .in_denominator          (in_ch.denominator),
    .out_reduced_numerator   (out_ch.reduced_numerator),
    .out_reduced_denominator (out_ch.reduced_denominator),
    .out_common_divisor      (out_ch.common_divisor)
  );

endmodule
